// ===== sv/quadratic_root_solver_core_macros.svh =====
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define QRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QRS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QRS_ASSERT(label, clk, rst_n, prop, msg)
`define QRS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== sv/qrs_pkg.sv =====
`timescale 1ns / 1ps
package qrs_pkg;
    localparam int CoefW = 16;
    localparam int RootW = 32;
    localparam int TolW = 32;
    localparam int DiscW = 34;           // b*b - 4ac fits 34 signed bits
    localparam int RadW = 58;            // disc << 24, nonnegative
    localparam int SqrtW = 29;           // floor(sqrt) of a 58 bit value
    localparam int NumW = 31;            // -b*4096 +/- s
    localparam int DenW = 17;
    localparam int QuoW = 31;
    localparam logic [TolW-1:0] TolReset = 32'd1678;

    typedef enum logic [1:0] {
        ST_REAL = 2'd0,
        ST_IMAG = 2'd1,
        ST_AZERO = 2'd2
    } status_t;

    // fields carried alongside the pipeline
    typedef struct packed {
        logic signed [CoefW-1:0] a;
        logic signed [CoefW-1:0] b;
        logic signed [CoefW-1:0] c;
        status_t                 status;
    } side_t;
endpackage

// ===== sv/qrs_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt_pipe
    import qrs_pkg::*;
#(
    parameter int W = RadW,
    parameter int SW = SqrtW,
    parameter int XW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  in_rad,
    input  logic [XW-1:0] in_side,
    output logic          out_valid,
    output logic [SW-1:0] out_root,
    output logic [XW-1:0] out_side
);
    localparam int RW = SW + 2;
    logic [SW:1]   v_reg    ;
    logic [W-1:0]  rad_reg  [1:SW];
    logic [RW-1:0] rem_reg  [1:SW];
    logic [SW-1:0] q_reg    [1:SW];
    logic [XW-1:0] side_reg [1:SW];

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (en) v_reg <= {v_reg[SW-1:1], in_valid};
    end

    for (genvar i = 0; i < SW; i++) begin : g_st
        logic [W-1:0]  rad_i;
        logic [RW-1:0] rem_i;
        logic [SW-1:0] q_i;
        logic [XW-1:0] side_i;
        logic [RW-1:0] rem_s;
        logic [RW-1:0] trial;
        logic [RW-1:0] diff;
        if (i == 0) begin : g_first
            assign rad_i = in_rad;
            assign rem_i = '0;
            assign q_i = '0;
            assign side_i = in_side;
        end else begin : g_next
            assign rad_i = rad_reg[i];
            assign rem_i = rem_reg[i];
            assign q_i = q_reg[i];
            assign side_i = side_reg[i];
        end
        always_comb begin
            rem_s = {rem_i[RW-3:0], rad_i[W-1-2*i -: 2]};
            trial = {q_i, 2'b01};
            diff = rem_s - trial;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i+1] <= rad_i;
                side_reg[i+1] <= side_i;
                if (rem_s >= trial) begin
                    rem_reg[i+1] <= diff;
                    q_reg[i+1] <= {q_i[SW-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= rem_s;
                    q_reg[i+1] <= {q_i[SW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[SW];
    assign out_root = q_reg[SW];
    assign out_side = side_reg[SW];
endmodule

// ===== sv/qrs_div_pipe.sv =====
`timescale 1ns / 1ps
// Two parallel pipelined restoring dividers sharing a divisor; truncates toward zero.
module qrs_div_pipe
    import qrs_pkg::*;
#(
    parameter int NW = NumW,
    parameter int DW = DenW,
    parameter int XW = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [NW-1:0] in_num_p,
    input  logic signed [NW-1:0] in_num_m,
    input  logic signed [DW-1:0] in_den,
    input  logic [XW-1:0]        in_side,
    output logic                 out_valid,
    output logic signed [NW-1:0] out_q_p,
    output logic signed [NW-1:0] out_q_m,
    output logic [XW-1:0]        out_side
);
    localparam int RW = DW + 1;
    logic [NW:1]   v;
    logic [NW-1:0] np [1:NW];
    logic [NW-1:0] nm [1:NW];
    logic [RW-1:0] rp [1:NW];
    logic [RW-1:0] rm [1:NW];
    logic [DW-1:0] d  [1:NW];
    logic          sp [1:NW];
    logic          sm [1:NW];
    logic [XW-1:0] sd [1:NW];

    always_ff @(posedge aclk) begin
        if (!aresetn) v <= '0;
        else if (en) v <= {v[NW-1:1], in_valid};
    end

    for (genvar i = 0; i < NW; i++) begin : g_st
        logic [NW-1:0] np_i, nm_i;
        logic [RW-1:0] rp_i, rm_i;
        logic [DW-1:0] d_i;
        logic          sp_i, sm_i;
        logic [XW-1:0] sd_i;
        logic [RW-1:0] tp, tm;
        if (i == 0) begin : g_first
            // magnitudes in front; sign of quotient kept aside
            assign np_i = in_num_p[NW-1] ? NW'(-in_num_p) : NW'(in_num_p);
            assign nm_i = in_num_m[NW-1] ? NW'(-in_num_m) : NW'(in_num_m);
            assign rp_i = '0;
            assign rm_i = '0;
            assign d_i = in_den[DW-1] ? DW'(-in_den) : DW'(in_den);
            assign sp_i = in_num_p[NW-1] ^ in_den[DW-1];
            assign sm_i = in_num_m[NW-1] ^ in_den[DW-1];
            assign sd_i = in_side;
        end else begin : g_next
            assign np_i = np[i];
            assign nm_i = nm[i];
            assign rp_i = rp[i];
            assign rm_i = rm[i];
            assign d_i = d[i];
            assign sp_i = sp[i];
            assign sm_i = sm[i];
            assign sd_i = sd[i];
        end
        always_comb begin
            tp = {rp_i[RW-2:0], np_i[NW-1]};
            tm = {rm_i[RW-2:0], nm_i[NW-1]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d[i+1] <= d_i;
                sp[i+1] <= sp_i;
                sm[i+1] <= sm_i;
                sd[i+1] <= sd_i;
                if (tp >= {1'b0, d_i}) begin
                    rp[i+1] <= tp - {1'b0, d_i};
                    np[i+1] <= {np_i[NW-2:0], 1'b1};
                end else begin
                    rp[i+1] <= tp;
                    np[i+1] <= {np_i[NW-2:0], 1'b0};
                end
                if (tm >= {1'b0, d_i}) begin
                    rm[i+1] <= tm - {1'b0, d_i};
                    nm[i+1] <= {nm_i[NW-2:0], 1'b1};
                end else begin
                    rm[i+1] <= tm;
                    nm[i+1] <= {nm_i[NW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v[NW];
    assign out_q_p = sp[NW] ? -$signed(np[NW]) : $signed(np[NW]);
    assign out_q_m = sm[NW] ? -$signed(nm[NW]) : $signed(nm[NW]);
    assign out_side = sd[NW];
endmodule

// ===== sv/qrs_residual.sv =====
`timescale 1ns / 1ps
// Residual check of one root: a*r*r + b*r*4096 + c*2^24, four stages.
module qrs_residual
    import qrs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [CoefW-1:0] a,
    input  logic signed [CoefW-1:0] b,
    input  logic signed [CoefW-1:0] c,
    input  logic signed [QuoW-1:0]  r,
    input  logic [TolW-1:0]         tol,
    output logic                    pass
);
    // stage 1: a*r and b*r
    logic signed [47:0] ar_reg, br_reg;
    logic signed [QuoW-1:0] r1_reg;
    logic signed [CoefW-1:0] c1_reg;
    logic [TolW-1:0] t1_reg;
    // stage 2: lower and upper parts of (a*r)*r, and the b and c terms
    logic signed [63:0] hi_reg;
    logic [47:0] lo_reg;
    logic signed [63:0] lin_reg;
    logic [TolW-1:0] t2_reg;
    // stage 3: sum
    logic signed [63:0] sum_reg;
    logic [TolW-1:0] t3_reg;
    logic [63:0] mag;

    always_ff @(posedge aclk) begin
        if (en) begin
            ar_reg <= 48'(a * r);
            br_reg <= 48'(b * r);
            r1_reg <= r;
            c1_reg <= c;
            t1_reg <= tol;
            // split r: r = rh*2^16 + rl (rl unsigned)
            hi_reg <= 64'(ar_reg * $signed(r1_reg[QuoW-1:16])) <<< 16;
            lo_reg <= 48'(ar_reg * $signed({1'b0, r1_reg[15:0]}));
            lin_reg <= (64'(br_reg) <<< 12) + (64'(c1_reg) <<< 24);
            t2_reg <= t1_reg;
            sum_reg <= hi_reg + 64'($signed(lo_reg)) + lin_reg;
            t3_reg <= t2_reg;
            pass <= mag <= 64'(t3_reg);
        end
    end
    assign mag = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
endmodule

// ===== sv/quadratic_root_solver_core.sv =====
`timescale 1ns / 1ps
// Quadratic root solver, fully pipelined.
// Pipeline: 2 front + 29 sqrt + 31 divide + 4 residual + 1 output = 67 register stages.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset: aresetn synchronous active low clears all valid bits and restores
// residual_tolerance to 1678.
module quadratic_root_solver_core
    import qrs_pkg::*;
#(
    parameter logic [TolW-1:0] TOL_RESET = TolReset
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [TolW-1:0] cfg_wdata,
    input  logic            s_tvalid,
    output logic            s_tready,
    // coef_quad[15:0], coef_lin[31:16], coef_const[47:32]
    input  logic [47:0]     s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // status[1:0], root_plus[33:2], root_minus[65:34], root_small[97:66],
    // plus_verified[98], minus_verified[99], zeros above
    output logic [103:0]    m_tdata
);
    localparam int XW = $bits(side_t);

    logic [TolW-1:0] tol_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) tol_reg <= TOL_RESET;
        else if (cfg_we) tol_reg <= cfg_wdata;
    end

    // Whole pipeline advances when the output register can take a new item.
    logic en;
    logic out_v_reg;
    assign en = !out_v_reg || m_tready;
    assign s_tready = en;

    // front stage 1: discriminant products, zero leading coefficient flag
    logic v1_reg;
    side_t s1_reg;
    logic signed [DiscW-1:0] bb_reg, ac4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_tvalid;
        if (en) begin
            s1_reg.a <= s_tdata[15:0];
            s1_reg.b <= s_tdata[31:16];
            s1_reg.c <= s_tdata[47:32];
            s1_reg.status <= (s_tdata[15:0] == '0) ? ST_AZERO : ST_REAL;
            bb_reg <= DiscW'($signed(s_tdata[31:16]) * $signed(s_tdata[31:16]));
            ac4_reg <= DiscW'($signed(s_tdata[15:0]) * $signed(s_tdata[47:32])) <<< 2;
        end
    end

    // front stage 2: discriminant, status, radicand
    logic v2_reg;
    side_t s2_reg;
    logic [RadW-1:0] rad_reg;
    logic signed [DiscW-1:0] disc;
    status_t st2_w;
    assign disc = bb_reg - ac4_reg;
    // a zero leading coefficient wins over a negative discriminant
    assign st2_w = (s1_reg.status == ST_REAL && disc < 0) ? ST_IMAG : s1_reg.status;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
        if (en) begin
            s2_reg.a <= s1_reg.a;
            s2_reg.b <= s1_reg.b;
            s2_reg.c <= s1_reg.c;
            s2_reg.status <= st2_w;
            rad_reg <= disc[DiscW-1] ? '0 : {disc[RadW-25:0], 24'd0};
        end
    end

    logic sq_v;
    logic [SqrtW-1:0] sq_root;
    logic [XW-1:0] sq_side_w;
    side_t sq_side;
    qrs_sqrt_pipe #(.W(RadW), .SW(SqrtW), .XW(XW)) u_sqrt (
        .aclk, .aresetn, .en,
        .in_valid(v2_reg), .in_rad(rad_reg), .in_side(s2_reg),
        .out_valid(sq_v), .out_root(sq_root), .out_side(sq_side_w)
    );
    assign sq_side = side_t'(sq_side_w);

    logic signed [NumW-1:0] nb, np, nm;
    logic signed [DenW-1:0] den;
    assign nb = NumW'(-(NumW'(sq_side.b) <<< 12));
    assign np = nb + NumW'({1'b0, sq_root});
    assign nm = nb - NumW'({1'b0, sq_root});
    // a zero leading coefficient gets divisor 1 instead of zero; such items are flagged and their roots forced to zero
    assign den = (sq_side.a == '0) ? DenW'(1) : DenW'(sq_side.a) <<< 1;

    logic dv_v;
    logic signed [QuoW-1:0] qp, qm;
    logic [XW-1:0] dv_side_w;
    side_t dv_side;
    qrs_div_pipe #(.NW(NumW), .DW(DenW), .XW(XW)) u_div (
        .aclk, .aresetn, .en,
        .in_valid(sq_v), .in_num_p(np), .in_num_m(nm), .in_den(den), .in_side(sq_side),
        .out_valid(dv_v), .out_q_p(qp), .out_q_m(qm), .out_side(dv_side_w)
    );
    assign dv_side = side_t'(dv_side_w);

    logic pass_p, pass_m;
    qrs_residual u_res_p (.aclk, .en, .a(dv_side.a), .b(dv_side.b), .c(dv_side.c),
        .r(qp), .tol(tol_reg), .pass(pass_p));
    qrs_residual u_res_m (.aclk, .en, .a(dv_side.a), .b(dv_side.b), .c(dv_side.c),
        .r(qm), .tol(tol_reg), .pass(pass_m));

    // delay roots and status through four registers to line up with the residual checks
    localparam int RD = 4;
    logic [RD-1:0] rv_reg;
    status_t st_d [RD];
    logic signed [QuoW-1:0] rp_d [RD];
    logic signed [QuoW-1:0] rm_d [RD];
    always_ff @(posedge aclk) begin
        if (!aresetn) rv_reg <= '0;
        else if (en) rv_reg <= {rv_reg[RD-2:0], dv_v};
        if (en) begin
            st_d[0] <= dv_side.status;
            rp_d[0] <= qp;
            rm_d[0] <= qm;
            for (int i = 1; i < RD; i++) begin
                st_d[i] <= st_d[i-1];
                rp_d[i] <= rp_d[i-1];
                rm_d[i] <= rm_d[i-1];
            end
        end
    end

    // output register
    logic real_w;
    logic signed [RootW-1:0] orp, orm;
    assign real_w = st_d[RD-1] == ST_REAL;
    assign orp = real_w ? RootW'(rp_d[RD-1]) : '0;
    assign orm = real_w ? RootW'(rm_d[RD-1]) : '0;
    logic [103:0] out_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= rv_reg[RD-1];
        if (en) begin
            out_d_reg <= {4'd0, real_w & pass_m, real_w & pass_p,
                          (orp < orm) ? orp : orm, orm, orp, st_d[RD-1]};
        end
    end
    assign m_tvalid = out_v_reg;
    assign m_tdata = out_d_reg;

    `include "quadratic_root_solver_core_macros.svh"
    `QRS_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "held item changed")
    `QRS_ASSERT(a_stat, aclk, aresetn, m_tvalid |-> m_tdata[1:0] != 2'd3, "bad status")
    `QRS_ASSERT(a_zero, aclk, aresetn, m_tvalid && m_tdata[1:0] != ST_REAL |-> m_tdata[99:2] == '0, "roots not cleared")
    `QRS_ASSERT_RST(a_rst, aclk, !aresetn |=> !m_tvalid, "valid after reset")
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import qrs_pkg::*;

    // solver result as carried on m_tdata
    typedef struct {
        status_t          status;
        logic signed [31:0] root_plus;
        logic signed [31:0] root_minus;
        logic signed [31:0] root_small;
        logic             plus_ok;
        logic             minus_ok;
    } roots_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    localparam int DrainCycles = 100;
    localparam int WatchdogLimit = 20000;
    localparam int HoldCycles = 300;

    roots_t      pending_roots[$];
    logic [31:0] tolerance = TolReset;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          hold_cycles = 0;   // long receiver hold-off, in cycles
    int          hold_requests = 0; // bumped by a test to ask for a hold-off
    int          hold_seen = 0;
    int          burst_left = 0;

    always #4 aclk = ~aclk;

    quadratic_root_solver_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Q.24 residual magnitude, wrapping 64-bit arithmetic
    function automatic logic [63:0] residual(longint a, longint b, longint c, longint r);
        logic [63:0] sum;
        sum = a * r * r + b * r * 4096 + c * 64'd16777216;
        if (sum[63]) sum = -sum;
        return sum;
    endfunction

    function automatic roots_t solve_quadratic(logic [47:0] coefs);
        roots_t o;
        longint a, b, c, d, s, rp, rm;
        a = longint'($signed(coefs[15:0]));
        b = longint'($signed(coefs[31:16]));
        c = longint'($signed(coefs[47:32]));
        o = '{ST_REAL, 0, 0, 0, 1'b0, 1'b0};
        if (a == 0) begin
            o.status = ST_AZERO;
            return o;
        end
        d = b * b - 4 * a * c;
        if (d < 0) begin
            o.status = ST_IMAG;
            return o;
        end
        s = longint'(isqrt(64'(d) << 24));
        rp = (-b * 4096 + s) / (2 * a);   // truncates toward zero
        rm = (-b * 4096 - s) / (2 * a);
        o.root_plus = rp[31:0];
        o.root_minus = rm[31:0];
        o.root_small = (rp < rm) ? rp[31:0] : rm[31:0];
        o.plus_ok = residual(a, b, c, rp) <= {32'd0, tolerance};
        o.minus_ok = residual(a, b, c, rm) <= {32'd0, tolerance};
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge aclk) begin
        roots_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_roots.size() == 0) begin
                report("unexpected item", 32'(m_tdata[1:0]), 32'd0);
            end else begin
                w = pending_roots.pop_front();
                if (m_tdata[1:0] !== w.status)
                    report("status", 32'(m_tdata[1:0]), 32'(w.status));
                if (m_tdata[33:2] !== w.root_plus) report("root_plus", m_tdata[33:2], w.root_plus);
                if (m_tdata[65:34] !== w.root_minus)
                    report("root_minus", m_tdata[65:34], w.root_minus);
                if (m_tdata[97:66] !== w.root_small)
                    report("root_small", m_tdata[97:66], w.root_small);
                if (m_tdata[98] !== w.plus_ok)
                    report("plus_verified", 32'(m_tdata[98]), 32'(w.plus_ok));
                if (m_tdata[99] !== w.minus_ok)
                    report("minus_verified", 32'(m_tdata[99]), 32'(w.minus_ok));
            end
        end
    end

    // receiver: own stall pattern plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_cycles <= HoldCycles;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // send one item, with bursty gaps before it
    task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                              logic signed [15:0] c);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_roots.push_back(solve_quadratic({c, b, a}));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tolerance = value;
    endtask

    // extremes, zero leading coefficient, imaginary, double and exact roots
    task automatic test_directed();
        send_coefs(0, 5, 3);
        send_coefs(0, 0, 0);
        send_coefs(1, 0, 1);
        send_coefs(1, -3, 2);
        send_coefs(1, 2, 1);
        send_coefs(-1, 0, 4);
        send_coefs(2, 3, -5);
        send_coefs(1, 0, -2);
        send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
        send_coefs(1, 16'sh8000, 0);
        send_coefs(1, 16'sh7fff, 16'sh8000);
        send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff);
        send_coefs(-1, 16'sh8000, 16'sh7fff);
        send_coefs(1, 16'sh8000, 16'sh8000);
        send_coefs(16'sh7fff, 0, 16'sh8000);
        send_coefs(3, 1, 0);
        send_coefs(-1, -1, -1);
        drain();
    endtask

    task automatic test_random(int count);
        logic signed [15:0] a, b, c;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: begin   // small values, frequent verified roots
                    a = 16'($urandom_range(0, 40)) - 16'sd20;
                    b = 16'($urandom_range(0, 200)) - 16'sd100;
                    c = 16'($urandom_range(0, 200)) - 16'sd100;
                end
                1: begin   // b from two integer roots times a, c drawn on its own
                    a = $signed(16'($urandom_range(1, 8)));
                    b = -a * (16'($urandom_range(0, 20)) - 16'sd10)
                        - a * (16'($urandom_range(0, 20)) - 16'sd10);
                    c = 16'($urandom_range(0, 60)) - 16'sd30;
                end
                default: begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                    c = 16'($urandom);
                end
            endcase
            if ($urandom_range(0, 40) == 0) a = 0;
            send_coefs(a, b, c);
        end
        drain();
    endtask

    // receiver holds off long while items keep coming
    task automatic test_backpressure();
        hold_requests++;
        for (int i = 0; i < 150; i++) begin
            send_coefs(16'($urandom_range(1, 500)), 16'($urandom), 16'($urandom));
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(600);
        write_tolerance(0);
        test_directed();
        test_random(400);
        write_tolerance(32'hffff_ffff);
        test_random(400);
        write_tolerance($urandom);
        test_backpressure();
        write_tolerance(32'd1 << 20);
        test_random(350);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
